### hw/rtl/clb_pkg.sv
package clb_pkg;

    localparam int MAX_SIDE_CELLS = 16;
    localparam int MAX_CELLS      = 4096;
    localparam int MAX_SLOTS      = 8;
    localparam int DIMS           = 3;

    localparam int SIDE_W  = $clog2(MAX_SIDE_CELLS);
    localparam int NCELL_W = SIDE_W + 1;
    localparam int CELL_W  = $clog2(MAX_CELLS);
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int SADDR_W = CELL_W + SLOT_W;
    localparam int CAP_W   = 4;
    localparam int CNT_W   = 17;
    localparam int PIDX_W  = 16;
    localparam int POS_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 32;
    localparam int IN_W    = 3 * POS_W;
    localparam int OUT_W   = 64;
    localparam int LIN_W   = 2 * SIDE_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] NEED_RESET = CNT_W'(2);

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_CLR_DONE,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef enum logic [2:0] {
        CU_IDLE,
        CU_MX,
        CU_MY,
        CU_MZ,
        CU_CZ,
        CU_LIN_Y,
        CU_LIN_X,
        CU_DONE
    } t_cu_step;

    typedef struct packed {
        logic              done;
        logic [CELL_W-1:0] cell_num;
    } t_cu_res;

    typedef struct packed {
        logic [PIDX_W-1:0] point;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
    } t_slot_entry;

    function automatic logic [NCELL_W-1:0] eff_cells(input logic [NCELL_W-1:0] c);
        logic [NCELL_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = NCELL_W'(1);
        end else if (c > NCELL_W'(MAX_SIDE_CELLS)) begin
            r = NCELL_W'(MAX_SIDE_CELLS);
        end
        return r;
    endfunction

    function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CAP_W'(1);
        end else if (c > CAP_W'(MAX_SLOTS)) begin
            r = CAP_W'(MAX_SLOTS);
        end
        return r;
    endfunction

    // Floor of the product is the upper word; it clamps to the last cell of the axis.
    function automatic logic [SIDE_W-1:0] clamp_axis(input logic [POS_W-1:0] whole,
                                                     input logic [NCELL_W-1:0] cells,
                                                     input logic used);
        logic [NCELL_W-1:0] last;
        logic [SIDE_W-1:0]  r;
        last = cells - NCELL_W'(1);
        if (!used) begin
            r = '0;
        end else if (whole > POS_W'(last)) begin
            r = last[SIDE_W-1:0];
        end else begin
            r = whole[SIDE_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/clb_cell_unit.sv
module clb_cell_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [clb_pkg::POS_W-1:0]      i_pos_x,
    input  logic [clb_pkg::POS_W-1:0]      i_pos_y,
    input  logic [clb_pkg::POS_W-1:0]      i_pos_z,
    input  logic [clb_pkg::POS_W-1:0]      i_inv_x,
    input  logic [clb_pkg::POS_W-1:0]      i_inv_y,
    input  logic [clb_pkg::POS_W-1:0]      i_inv_z,
    input  logic [clb_pkg::NCELL_W-1:0]    i_cells_x,
    input  logic [clb_pkg::NCELL_W-1:0]    i_cells_y,
    input  logic [clb_pkg::NCELL_W-1:0]    i_cells_z,
    output clb_pkg::t_cu_res               o_res
);

    clb_pkg::t_cu_step r_step, n_step;

    logic [clb_pkg::POS_W-1:0]    mult_a, mult_b;
    logic [2*clb_pkg::POS_W-1:0]  mult_p;
    logic [clb_pkg::POS_W-1:0]    r_hi;
    logic [clb_pkg::SIDE_W-1:0]   r_cx, r_cy, r_cz;
    logic [clb_pkg::LIN_W-1:0]    r_t;
    logic [clb_pkg::CELL_W-1:0]   r_cell;

    // The one multiplier serves the three axis scalings and both linearising steps.
    assign mult_p = {{clb_pkg::POS_W{1'b0}}, mult_a} * {{clb_pkg::POS_W{1'b0}}, mult_b};

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            clb_pkg::CU_IDLE:  if (i_start) n_step = clb_pkg::CU_MX;
            clb_pkg::CU_MX:    n_step = clb_pkg::CU_MY;
            clb_pkg::CU_MY:    n_step = clb_pkg::CU_MZ;
            clb_pkg::CU_MZ:    n_step = clb_pkg::CU_CZ;
            clb_pkg::CU_CZ:    n_step = clb_pkg::CU_LIN_Y;
            clb_pkg::CU_LIN_Y: n_step = clb_pkg::CU_LIN_X;
            clb_pkg::CU_LIN_X: n_step = clb_pkg::CU_DONE;
            clb_pkg::CU_DONE:  n_step = clb_pkg::CU_IDLE;
            default:           n_step = clb_pkg::CU_IDLE;
        endcase
    end

    always_comb begin
        mult_a = '0;
        mult_b = '0;
        unique case (r_step)
            clb_pkg::CU_MX: begin
                mult_a = i_pos_x;
                mult_b = i_inv_x;
            end
            clb_pkg::CU_MY: begin
                mult_a = i_pos_y;
                mult_b = i_inv_y;
            end
            clb_pkg::CU_MZ: begin
                mult_a = i_pos_z;
                mult_b = i_inv_z;
            end
            clb_pkg::CU_LIN_Y: begin
                mult_a = clb_pkg::POS_W'(r_cz);
                mult_b = clb_pkg::POS_W'(i_cells_y);
            end
            clb_pkg::CU_LIN_X: begin
                mult_a = clb_pkg::POS_W'(r_t);
                mult_b = clb_pkg::POS_W'(i_cells_x);
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= clb_pkg::CU_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            clb_pkg::CU_MX: r_hi <= mult_p[2*clb_pkg::POS_W-1:clb_pkg::POS_W];
            clb_pkg::CU_MY: begin
                r_hi <= mult_p[2*clb_pkg::POS_W-1:clb_pkg::POS_W];
                r_cx <= clb_pkg::clamp_axis(r_hi, i_cells_x, clb_pkg::DIMS > 0);
            end
            clb_pkg::CU_MZ: begin
                r_hi <= mult_p[2*clb_pkg::POS_W-1:clb_pkg::POS_W];
                r_cy <= clb_pkg::clamp_axis(r_hi, i_cells_y, clb_pkg::DIMS > 1);
            end
            clb_pkg::CU_CZ:
                r_cz <= clb_pkg::clamp_axis(r_hi, i_cells_z, clb_pkg::DIMS > 2);
            clb_pkg::CU_LIN_Y:
                r_t <= mult_p[clb_pkg::LIN_W-1:0] + clb_pkg::LIN_W'(r_cy);
            clb_pkg::CU_LIN_X:
                r_cell <= mult_p[clb_pkg::CELL_W-1:0] + clb_pkg::CELL_W'(r_cx);
            default: ;
        endcase
    end

    assign o_res.done     = (r_step == clb_pkg::CU_DONE);
    assign o_res.cell_num = r_cell;

endmodule

### hw/rtl/clb_slot_store.sv
module clb_slot_store (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [clb_pkg::CELL_W+clb_pkg::SLOT_W-1:0] i_addr,
    input  clb_pkg::t_slot_entry                     i_data
);

    // Slot contents are held for the consumer of the cell list; this port only writes.
    clb_pkg::t_slot_entry mem_slot [clb_pkg::MAX_CELLS*clb_pkg::MAX_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_slot[i_addr] <= i_data;
        end
    end

endmodule

### hw/rtl/cell_list_binning_top.sv
// Channel     Direction  Signals                          Contents (lowest bit up)
// s_axis      in         tvalid tready tdata[95:0] tuser  tdata: pos_x, pos_y, pos_z; tuser: cmd
// m_axis      out        tvalid tready tdata[63:0]        cell_index, slot, point_index,
//                                                         stored, overflow, needed_capacity
// cfg         in         i_cfg_we i_cfg_idx i_cfg_data    register write, no read-back
//
// An insert gives its result after seven steps of the shared multiplier sequencer,
// a registered read of the cell count memory and the update. s_axis_tready returns
// in the same cycle that m_axis_tvalid rises, so one insert is done before the next
// is taken. A clear sweeps the 4096-entry count memory, one entry a cycle, and then
// gives its result. After reset the same sweep runs first, with s_axis_tready low.
// One item is in work at a time; a result waits in the output register and the
// update stalls while it is not taken.
module cell_list_binning_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [clb_pkg::IN_W-1:0]          s_axis_tdata,  // pos_x, pos_y, pos_z
    input  logic                              s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [clb_pkg::OUT_W-1:0]         m_axis_tdata,  // cell_index, slot,
                                                             // point_index, stored,
                                                             // overflow, needed_capacity
    input  logic                              i_cfg_we,
    input  logic [clb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [clb_pkg::CFG_W-1:0]         i_cfg_data
);

    clb_pkg::t_state r_state, n_state;

    logic [clb_pkg::NCELL_W-1:0] r_cells_x, r_cells_y, r_cells_z;
    logic [clb_pkg::POS_W-1:0]   r_inv_x, r_inv_y, r_inv_z;
    logic [clb_pkg::CAP_W-1:0]   r_capacity;

    logic [clb_pkg::POS_W-1:0]   r_pos_x, r_pos_y, r_pos_z;
    logic                        r_clr_cmd;
    logic [clb_pkg::CELL_W-1:0]  r_sweep;
    logic [clb_pkg::CNT_W-1:0]   r_pcnt;
    logic                        r_ovf, n_ovf;
    logic [clb_pkg::CNT_W-1:0]   r_need, n_need;
    logic [clb_pkg::CNT_W-1:0]   r_cnt_rd;

    logic                        r_m_valid;
    logic [clb_pkg::OUT_W-1:0]   r_m_data, n_m_data;

    logic [clb_pkg::CNT_W-1:0]   mem_cnt [clb_pkg::MAX_CELLS];

    logic                        in_xfer, out_free, upd_go, clr_go;
    logic [clb_pkg::CAP_W-1:0]   cap_eff;
    logic                        do_store;
    logic [clb_pkg::CNT_W-1:0]   need_cnt;
    logic [clb_pkg::PIDX_W-1:0]  slot_sat;
    logic                        cnt_we;
    logic [clb_pkg::CELL_W-1:0]  cnt_waddr;
    logic [clb_pkg::CNT_W-1:0]   cnt_wdata;
    logic                        slot_we;
    logic [clb_pkg::SADDR_W-1:0] slot_addr;
    clb_pkg::t_slot_entry        slot_data;
    clb_pkg::t_cu_res            cu_res;

    assign s_axis_tready = (r_state == clb_pkg::ST_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign upd_go   = (r_state == clb_pkg::ST_UPDATE) && out_free;
    assign clr_go   = (r_state == clb_pkg::ST_CLR_DONE) && out_free;
    assign cap_eff  = clb_pkg::eff_capacity(r_capacity);

    clb_cell_unit u_cell_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer && (s_axis_tuser == clb_pkg::CMD_INSERT)),
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_pos_z   (r_pos_z),
        .i_inv_x   (r_inv_x),
        .i_inv_y   (r_inv_y),
        .i_inv_z   (r_inv_z),
        .i_cells_x (clb_pkg::eff_cells(r_cells_x)),
        .i_cells_y (clb_pkg::eff_cells(r_cells_y)),
        .i_cells_z (clb_pkg::eff_cells(r_cells_z)),
        .o_res     (cu_res)
    );

    clb_slot_store u_slot_store (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_addr (slot_addr),
        .i_data (slot_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clb_pkg::ST_CLEAR: begin
                if (r_sweep == clb_pkg::CELL_W'(clb_pkg::MAX_CELLS - 1)) begin
                    n_state = r_clr_cmd ? clb_pkg::ST_CLR_DONE : clb_pkg::ST_IDLE;
                end
            end
            clb_pkg::ST_CLR_DONE: if (out_free) n_state = clb_pkg::ST_IDLE;
            clb_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (s_axis_tuser == clb_pkg::CMD_CLEAR) ? clb_pkg::ST_CLEAR
                                                                   : clb_pkg::ST_CALC;
                end
            end
            clb_pkg::ST_CALC:   if (cu_res.done) n_state = clb_pkg::ST_READ;
            clb_pkg::ST_READ:   n_state = clb_pkg::ST_UPDATE;
            clb_pkg::ST_UPDATE: if (out_free) n_state = clb_pkg::ST_IDLE;
            default:            n_state = clb_pkg::ST_IDLE;
        endcase
    end

    // Update arithmetic for an insert, the writes to both memories (also the clear sweep) and the next output word.
    always_comb begin
        do_store  = (r_cnt_rd < clb_pkg::CNT_W'(cap_eff)) && !r_ovf;
        need_cnt  = (r_cnt_rd == clb_pkg::CNT_MAX) ? clb_pkg::CNT_MAX
                                                    : r_cnt_rd + clb_pkg::CNT_W'(1);
        slot_sat  = (r_cnt_rd > clb_pkg::CNT_W'({clb_pkg::PIDX_W{1'b1}}))
                    ? {clb_pkg::PIDX_W{1'b1}} : r_cnt_rd[clb_pkg::PIDX_W-1:0];
        n_ovf     = r_ovf || !do_store;
        n_need    = r_need;
        if (!do_store && (need_cnt > r_need)) begin
            n_need = need_cnt;
        end

        cnt_we    = 1'b0;
        cnt_waddr = cu_res.cell_num;
        cnt_wdata = need_cnt;
        if (r_state == clb_pkg::ST_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_sweep;
            cnt_wdata = '0;
        end else if (upd_go) begin
            cnt_we = (r_cnt_rd != clb_pkg::CNT_MAX);
        end

        slot_we         = upd_go && do_store;
        slot_addr       = {cu_res.cell_num, r_cnt_rd[clb_pkg::SLOT_W-1:0]};
        slot_data.point = r_pcnt[clb_pkg::PIDX_W-1:0];
        slot_data.pos_x = r_pos_x;
        slot_data.pos_y = r_pos_y;
        slot_data.pos_z = r_pos_z;

        if (r_state == clb_pkg::ST_CLR_DONE) begin
            n_m_data = {{(clb_pkg::OUT_W - 46 - clb_pkg::CNT_W){1'b0}}, r_need, 46'b0};
        end else begin
            n_m_data = {{(clb_pkg::OUT_W - 46 - clb_pkg::CNT_W){1'b0}}, n_need, n_ovf,
                        do_store, r_pcnt[clb_pkg::PIDX_W-1:0], slot_sat, cu_res.cell_num};
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_waddr] <= cnt_wdata;
        end
        if (r_state == clb_pkg::ST_READ) begin
            r_cnt_rd <= mem_cnt[cu_res.cell_num];
        end
        if (in_xfer) begin
            r_pos_x <= s_axis_tdata[clb_pkg::POS_W-1:0];
            r_pos_y <= s_axis_tdata[2*clb_pkg::POS_W-1:clb_pkg::POS_W];
            r_pos_z <= s_axis_tdata[3*clb_pkg::POS_W-1:2*clb_pkg::POS_W];
        end
        if (upd_go || clr_go) begin
            r_m_data <= n_m_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= clb_pkg::ST_CLEAR;
            r_sweep    <= '0;
            r_clr_cmd  <= 1'b0;
            r_pcnt     <= '0;
            r_ovf      <= 1'b0;
            r_need     <= clb_pkg::NEED_RESET;
            r_m_valid  <= 1'b0;
            r_cells_x  <= clb_pkg::NCELL_W'(clb_pkg::MAX_SIDE_CELLS);
            r_cells_y  <= clb_pkg::NCELL_W'(clb_pkg::MAX_SIDE_CELLS);
            r_cells_z  <= clb_pkg::NCELL_W'(clb_pkg::MAX_SIDE_CELLS);
            r_inv_x    <= clb_pkg::POS_W'(65536);
            r_inv_y    <= clb_pkg::POS_W'(65536);
            r_inv_z    <= clb_pkg::POS_W'(65536);
            r_capacity <= clb_pkg::CAP_W'(2);
        end else begin
            r_state <= n_state;

            if (r_state == clb_pkg::ST_CLEAR) begin
                r_sweep <= r_sweep + clb_pkg::CELL_W'(1);
            end

            if (in_xfer && (s_axis_tuser == clb_pkg::CMD_CLEAR)) begin
                r_clr_cmd <= 1'b1;
                r_sweep   <= '0;
                r_pcnt    <= '0;
                r_ovf     <= 1'b0;
                r_need    <= clb_pkg::CNT_W'(cap_eff);
            end

            if (upd_go) begin
                r_pcnt <= r_pcnt + clb_pkg::CNT_W'(1);
                r_ovf  <= n_ovf;
                r_need <= n_need;
            end

            if (upd_go || clr_go) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    clb_pkg::CFG_CELLS_X:  r_cells_x  <= i_cfg_data[clb_pkg::NCELL_W-1:0];
                    clb_pkg::CFG_CELLS_Y:  r_cells_y  <= i_cfg_data[clb_pkg::NCELL_W-1:0];
                    clb_pkg::CFG_CELLS_Z:  r_cells_z  <= i_cfg_data[clb_pkg::NCELL_W-1:0];
                    clb_pkg::CFG_INV_X:    r_inv_x    <= i_cfg_data[clb_pkg::POS_W-1:0];
                    clb_pkg::CFG_INV_Y:    r_inv_y    <= i_cfg_data[clb_pkg::POS_W-1:0];
                    clb_pkg::CFG_INV_Z:    r_inv_z    <= i_cfg_data[clb_pkg::POS_W-1:0];
                    clb_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[clb_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
